// ===== hw/rtl/tci_pkg.sv =====
package tci_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;

    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    localparam int TS_SHL = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int TS_SHR = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

    localparam logic [7:0] SYM_FWD   = 8'h46;
    localparam logic [7:0] SYM_LEFT  = 8'h2B;
    localparam logic [7:0] SYM_RIGHT = 8'h2D;

    localparam logic [1:0] REG_TURN_ANGLE  = 2'd0;
    localparam logic [1:0] REG_STEP_LENGTH = 2'd1;
    localparam logic [1:0] REG_START_X     = 2'd2;
    localparam logic [1:0] REG_START_Y     = 2'd3;

    localparam logic [15:0]        TURN_ANGLE_RST  = 16'd10923;
    localparam logic [30:0]        STEP_LENGTH_RST = 31'd327680;
    localparam logic signed [31:0] START_X_RST     = 32'sd19660800;
    localparam logic signed [31:0] START_Y_RST     = 32'sd3276800;

    typedef struct packed {
        logic              accept;
        logic              iterate;
        logic [STEP_W-1:0] step;
        logic              negate;
        logic              mul_x;
        logic              mul_y;
        logic              round_y;
        logic              write;
    } dp_cmd_t;

    typedef struct packed {
        logic is_fwd;
    } dp_status_t;

    function automatic logic [31:0] atan_of(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] turn_step(input logic [15:0] t);
        logic [39:0] w;
        w = (40'(t) << TS_SHL) >> TS_SHR;
        return w[ANGLE_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/tci_ctrl.sv =====
module tci_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  tci_pkg::dp_status_t status,
    output tci_pkg::dp_cmd_t    cmd
);
    import tci_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CORD  = 3'd1;
    localparam logic [2:0] S_NEG   = 3'd2;
    localparam logic [2:0] S_MULX  = 3'd3;
    localparam logic [2:0] S_MULY  = 3'd4;
    localparam logic [2:0] S_RND   = 3'd5;
    localparam logic [2:0] S_WRITE = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              mvalid_reg, mvalid_next;
    logic              accept;
    logic              out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && status.is_fwd) begin
                    state_next = S_CORD;
                    step_next  = '0;
                end
            end
            S_CORD: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    state_next = S_NEG;
                end
            end
            S_NEG:  state_next = S_MULX;
            S_MULX: state_next = S_MULY;
            S_MULY: state_next = S_RND;
            S_RND:  state_next = S_WRITE;
            S_WRITE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.accept  = accept;
        cmd.iterate = (state_reg == S_CORD);
        cmd.step    = step_reg;
        cmd.negate  = (state_reg == S_NEG);
        cmd.mul_x   = (state_reg == S_MULX);
        cmd.mul_y   = (state_reg == S_MULY);
        cmd.round_y = (state_reg == S_RND);
        cmd.write   = (state_reg == S_WRITE) && out_free;
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.write) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// ===== hw/rtl/tci_dp.sv =====
module tci_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [7:0]          symbol,
    input  logic                first,
    input  tci_pkg::dp_cmd_t    cmd,
    output tci_pkg::dp_status_t status,
    output logic [127:0]        result
);
    import tci_pkg::*;

    logic [15:0]              turn_angle_reg;
    logic [30:0]              step_length_reg;
    logic signed [31:0]       start_x_reg, start_y_reg;
    logic signed [31:0]       pen_x_reg, pen_y_reg;
    logic [ANGLE_BITS-1:0]    heading_reg;
    logic signed [31:0]       x_reg, y_reg, z_reg;
    logic                     neg_reg;
    logic signed [62:0]       prod_reg;
    logic signed [32:0]       dx_reg, dy_reg;
    logic [127:0]             result_reg;

    logic [ANGLE_BITS-1:0]    head_eff;
    logic [31:0]              wide_angle;
    logic                     fold;
    logic signed [31:0]       y_sh, x_sh;
    logic [31:0]              atan_i;
    logic signed [31:0]       mul_in;
    logic signed [63:0]       prod_full;
    logic signed [32:0]       rounded;
    logic signed [33:0]       sum_x, sum_y;
    logic signed [31:0]       nx, ny;

    assign status.is_fwd = (symbol == SYM_FWD);

    assign head_eff   = first ? QUARTER : heading_reg;
    assign wide_angle = 32'(head_eff) << (32 - ANGLE_BITS);
    assign fold       = wide_angle[31] ^ wide_angle[30];

    assign y_sh   = y_reg >>> cmd.step;
    assign x_sh   = x_reg >>> cmd.step;
    assign atan_i = atan_of(ATAN_IDX_W'(cmd.step));

    assign mul_in    = cmd.mul_y ? y_reg : x_reg;
    assign prod_full = $signed({1'b0, step_length_reg}) * mul_in;
    assign rounded   = $signed(prod_reg[62:30]) + $signed({32'd0, prod_reg[29]});

    assign sum_x = 34'(pen_x_reg) + 34'(dx_reg);
    assign sum_y = 34'(pen_y_reg) + 34'(dy_reg);

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign nx = sat32(sum_x);
    assign ny = sat32(sum_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_angle_reg  <= TURN_ANGLE_RST;
            step_length_reg <= STEP_LENGTH_RST;
            start_x_reg     <= START_X_RST;
            start_y_reg     <= START_Y_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TURN_ANGLE:  turn_angle_reg  <= cfg_data[15:0];
                REG_STEP_LENGTH: step_length_reg <= cfg_data[30:0];
                REG_START_X:     start_x_reg     <= cfg_data;
                REG_START_Y:     start_y_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg   <= START_X_RST;
            pen_y_reg   <= START_Y_RST;
            heading_reg <= QUARTER;
        end else if (cmd.accept) begin
            if (first) begin
                pen_x_reg <= start_x_reg;
                pen_y_reg <= start_y_reg;
            end
            if (symbol == SYM_LEFT) begin
                heading_reg <= head_eff + turn_step(turn_angle_reg);
            end else if (symbol == SYM_RIGHT) begin
                heading_reg <= head_eff - turn_step(turn_angle_reg);
            end else begin
                heading_reg <= head_eff;
            end
        end else if (cmd.write) begin
            pen_x_reg <= nx;
            pen_y_reg <= ny;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            x_reg   <= GAIN_Q30;
            y_reg   <= '0;
            z_reg   <= {wide_angle[31] ^ fold, wide_angle[30:0]};
            neg_reg <= fold;
        end else if (cmd.iterate) begin
            if (!z_reg[31]) begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - $signed(atan_i);
            end else begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + $signed(atan_i);
            end
        end else if (cmd.negate && neg_reg) begin
            x_reg <= -x_reg;
            y_reg <= -y_reg;
        end
        if (cmd.mul_x || cmd.mul_y) begin
            prod_reg <= prod_full[62:0];
        end
        if (cmd.mul_y) begin
            dx_reg <= rounded;
        end
        if (cmd.round_y) begin
            dy_reg <= rounded;
        end
        if (cmd.write) begin
            result_reg <= {ny, nx, pen_y_reg, pen_x_reg};
        end
    end

    assign result = result_reg;

endmodule

// ===== hw/rtl/turtle_command_interpreter_unit.sv =====
// Turtle command interpreter. Each input word carries one command byte and a
// flag that restarts the pen at start_x/start_y heading along +y. '+' and '-'
// turn by turn_angle; 'F' produces one output word with the segment drawn,
// all coordinates signed Q16.16 with saturation on the end point. After its
// acceptance an 'F' occupies the block for CORDIC_STEPS iterations of the
// shared CORDIC rotator, then a negate step, a multiply of x then y on the
// single 32x31 multiplier, a rounding step and the output write, which
// waits while the output register is full and not taken. Other bytes are
// dropped. A finished segment waits in the output register while the next
// word is accepted. Start registers take effect at the next restart flag.
module turtle_command_interpreter_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // symbol
    input  logic         s_tuser,   // first
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // from_x, from_y, to_x, to_y
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import tci_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tci_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tci_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .symbol    (s_tdata),
        .first     (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .result    (m_tdata)
    );

endmodule
